// ----- src/las_pkg.sv -----
package las_pkg;

	localparam int MAX_ELEMENTS_DEF = 256;
	localparam int VALUE_BITS_DEF   = 8;

	localparam int VALUE_W   = 8;
	localparam int LONGEST_W = 9;

	// length of the shortest chain, started when an earlier position has none
	localparam int MIN_CHAIN = 2;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [LONGEST_W-1:0] longest;
		logic                 dropped;
	} result_t;

	typedef struct packed {
		logic start;
		logic ack;
	} eng_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

endpackage

// ----- src/las_engine.sv -----
module las_engine import las_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  eng_ctrl_t ctrl,
	input  item_t     item,
	output eng_stat_t stat,
	output result_t   result
);

	localparam int JW     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW     = $clog2(MAX_ELEMENTS + 1);
	localparam int LW     = CW;
	localparam int DW     = VALUE_BITS + 1;
	localparam int WW     = VALUE_BITS + 2;
	localparam int AW     = JW + DW;
	localparam int CDEPTH = 1 << AW;
	localparam int VSLOTS = 1 << VALUE_BITS;

	localparam logic [DW-1:0] DIFF_OFF = DW'(1) << VALUE_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_STORE  = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [LW-1:0]         best_q;
	logic                  last_q;
	logic                  dropped_q;
	logic                  iss_q;
	logic [JW-1:0]         j_q;
	logic [VALUE_BITS-1:0] clr_q;
	logic                  vld_s1;
	logic                  lst_s1;
	logic                  vld_s2;
	logic                  lst_s2;
	logic                  vld_s3;
	logic                  lst_s3;

	logic [VALUE_BITS-1:0] v_q;
	logic                  seen_q;
	logic [JW-1:0]         j_s1;
	logic [VALUE_BITS-1:0] vrd_q;
	logic [JW-1:0]         j_s2;
	logic [DW-1:0]         d_s2;
	logic [VALUE_BITS-1:0] w_s2;
	logic                  wok_s2;
	logic [JW-1:0]         fp_q;
	logic [DW-1:0]         d_s3;
	logic [VALUE_BITS-1:0] w_s3;
	logic                  ok_s3;
	logic [VALUE_BITS-1:0] vfp_q;
	logic [LW-1:0]         crd_q;

	logic [VALUE_BITS-1:0] vmem [MAX_ELEMENTS];
	logic [LW-1:0]         cmem [CDEPTH];
	logic [JW-1:0]         fmem [VSLOTS];

	logic [JW-1:0] i_idx;
	logic [DW-1:0] d_s1;
	logic [WW-1:0] w_s1;
	logic          hit_s3;
	logic [LW-1:0] len_s3;
	logic          lst_issue;
	logic          start_go;

	assign i_idx     = count_q[JW-1:0];
	assign d_s1      = {1'b0, v_q} + DIFF_OFF - {1'b0, vrd_q};
	// value that would precede position j on this step: 2 * v[j] - v[i]
	assign w_s1      = {1'b0, vrd_q, 1'b0} - {2'b00, v_q};
	// a chain entry of row j is live only if that value occurs before j
	assign hit_s3    = ok_s3 && (vfp_q == w_s3);
	assign len_s3    = hit_s3 ? (crd_q + LW'(1)) : LW'(MIN_CHAIN);
	assign lst_issue = (CW'(j_q) + CW'(1)) == count_q;
	assign start_go  = (state_q == ST_IDLE) && ctrl.start;

	assign stat.busy      = (state_q != ST_IDLE);
	assign stat.done      = (state_q == ST_FINISH);
	assign result.longest = LONGEST_W'(best_q);
	assign result.dropped = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			count_q   <= '0;
			best_q    <= '0;
			last_q    <= 1'b0;
			dropped_q <= 1'b0;
			iss_q     <= 1'b0;
			j_q       <= '0;
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			lst_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			lst_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			lst_s3    <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			lst_s1 <= 1'b0;
			vld_s2 <= vld_s1;
			lst_s2 <= lst_s1;
			vld_s3 <= vld_s2;
			lst_s3 <= lst_s2;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VALUE_BITS'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (ctrl.start) begin
						last_q <= item.last;
						if (count_q == CW'(MAX_ELEMENTS)) begin
							dropped_q <= 1'b1;
							state_q   <= ST_FINISH;
						end else begin
							dropped_q <= 1'b0;
							if (count_q == '0) begin
								state_q <= ST_STORE;
							end else begin
								iss_q   <= 1'b1;
								j_q     <= '0;
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_WALK: begin
					if (iss_q) begin
						vld_s1 <= 1'b1;
						lst_s1 <= lst_issue;
						if (lst_issue) begin
							iss_q <= 1'b0;
						end else begin
							j_q <= j_q + JW'(1);
						end
					end
					if (vld_s3) begin
						if (len_s3 > best_q) begin
							best_q <= len_s3;
						end
						if (lst_s3) begin
							state_q <= ST_STORE;
						end
					end
				end
				ST_STORE: begin
					count_q <= count_q + CW'(1);
					if (best_q == '0) begin
						best_q <= LW'(1);
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (ctrl.ack) begin
						if (last_q) begin
							count_q <= '0;
							best_q  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk datapath: value read, difference and first-position lookup,
	// chain and predecessor reads, chain write; also the element store and table clear
	always_ff @(posedge clk) begin
		if (start_go) begin
			v_q    <= VALUE_BITS'(item.value);
			seen_q <= 1'b0;
		end else if (vld_s1 && (vrd_q == v_q)) begin
			seen_q <= 1'b1;
		end
		j_s1   <= j_q;
		vrd_q  <= vmem[j_q];
		j_s2   <= j_s1;
		d_s2   <= d_s1;
		w_s2   <= w_s1[VALUE_BITS-1:0];
		wok_s2 <= (w_s1[WW-1:VALUE_BITS] == 2'b00);
		fp_q   <= fmem[w_s1[VALUE_BITS-1:0]];
		d_s3   <= d_s2;
		w_s3   <= w_s2;
		ok_s3  <= wok_s2 && (fp_q < j_s2);
		vfp_q  <= vmem[fp_q];
		crd_q  <= cmem[{j_s2, d_s2}];
		if (state_q == ST_WALK && vld_s3) begin
			cmem[{i_idx, d_s3}] <= len_s3;
		end
		if (state_q == ST_STORE) begin
			vmem[i_idx] <= v_q;
			// keep the first position of each value in the sequence
			if (!seen_q) begin
				fmem[v_q] <= i_idx;
			end
		end
		if (state_q == ST_CLEAR) begin
			fmem[clr_q] <= '0;
		end
	end

endmodule

// ----- src/longest_arithmetic_subsequence.sv -----
// channel   direction  valid         stall         payload
// item      in         item_valid    item_stall    item   (value, last)
// result    out        result_valid  result_stall  result (longest, dropped)
//
// An element stored at position i > 0 keeps item_stall high for its whole work:
// one lookup per earlier position through a shared difference/lookup/increment
// unit, three pipeline stages of fill, store and handoff. The first element of
// a sequence only passes store and handoff, a dropped element only handoff.
// After reset item_stall stays high while all 2^VALUE_BITS entries of the
// first-position table clear; result_stall on a waiting result holds the rest.
module longest_arithmetic_subsequence import las_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	eng_ctrl_t ctrl;
	eng_stat_t stat;
	result_t   eng_result;
	logic      res_valid_q;
	result_t   res_q;
	logic      out_free;

	assign out_free   = !res_valid_q || !result_stall;
	assign ctrl.start = item_valid && !stat.busy;
	assign ctrl.ack   = out_free;
	assign item_stall = stat.busy;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	las_engine #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.item  (item),
		.stat  (stat),
		.result(eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.done && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && out_free) begin
			res_q <= eng_result;
		end
	end

endmodule

// ----- src/las_checker.sv -----
module las_checker import las_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one element at a time: stall right after an input transfer
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled while element in work");

	// a new result only comes out of an element in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without element in work");

endmodule

bind longest_arithmetic_subsequence las_checker u_checker (.*);
